### rtl/binary_rate_step_generator_defines.svh
// Assertion macros for the binary rate step generator.
`ifndef BINARY_RATE_STEP_GENERATOR_DEFINES_SVH
`define BINARY_RATE_STEP_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BRSG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset.
`define BRSG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BRSG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BRSG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/brsg_pkg.sv
package brsg_pkg;

   // Fixed port geometry
   localparam int NUM_IN_AXES    = 4;
   localparam int AXIS_COUNT_W   = 8;
   localparam int MAX_COUNT_BITS = 8;
   localparam int DEPTH_W        = 4;
   localparam int SEL_W          = 3;

   // Parameter defaults
   localparam int DEF_NUM_AXES   = 4;
   localparam int DEF_COUNT_BITS = 8;

   // Request kinds
   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   // First count-down index for each depth 1..8 (2^depth - 2)
   localparam logic [MAX_COUNT_BITS-1:0] START_INDEX_TABLE [MAX_COUNT_BITS] = '{
      8'd0, 8'd2, 8'd6, 8'd14, 8'd30, 8'd62, 8'd126, 8'd254
   };

   // Per-lane control from the sequencer
   typedef struct packed {
      logic             load_active;
      logic             load_pending;
      logic             promote;
      logic             step_en;
      logic [SEL_W-1:0] bit_sel;
   } lane_ctl_type;

   // Sequencer status toward the response path
   typedef struct packed {
      logic [NUM_IN_AXES-1:0] dir_out;
      logic                   step_valid;
      logic                   sub_done;
      logic                   load_refused;
   } ctrl_status_type;

   // One response transaction
   typedef struct packed {
      logic [NUM_IN_AXES-1:0] step_mask;
      logic [NUM_IN_AXES-1:0] dir_out;
      logic                   step_valid;
      logic                   sub_done;
      logic                   load_refused;
   } rsp_type;

   function automatic logic [MAX_COUNT_BITS-1:0] start_index(input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W-1:0] d1;
      d1 = depth - DEPTH_W'(1);
      return START_INDEX_TABLE[d1[SEL_W-1:0]];
   endfunction

endpackage

### rtl/brsg_lane.sv
module brsg_lane #(
   parameter int COUNT_BITS = brsg_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [brsg_pkg::AXIS_COUNT_W-1:0] axis_count,
   input  brsg_pkg::lane_ctl_type            ctl,
   output logic [COUNT_BITS-1:0]             dist_masked,
   output logic                              step
);
   import brsg_pkg::*;

   localparam int LSEL_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;

   logic [COUNT_BITS-1:0] active_count_ff, active_count_in;
   logic [COUNT_BITS-1:0] pending_count_ff, pending_count_in;

   assign dist_masked = axis_count[COUNT_BITS-1:0];

   // Active slot: direct load or promotion of the pending count
   always_comb begin
      active_count_in = active_count_ff;
      if (ctl.load_active) begin
         active_count_in = dist_masked;
      end else if (ctl.promote) begin
         active_count_in = pending_count_ff;
      end
   end

   always_comb begin
      pending_count_in = pending_count_ff;
      if (ctl.load_pending) begin
         pending_count_in = dist_masked;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= '0;
      end else begin
         active_count_ff <= active_count_in;
      end
   end

   // Pending count is only read after a load wrote it
   always_ff @(posedge clock) begin
      pending_count_ff <= pending_count_in;
   end

   // Bit select for the current slot
   assign step = ctl.step_en & active_count_ff[ctl.bit_sel[LSEL_W-1:0]];

endmodule

### rtl/brsg_ctrl.sv
module brsg_ctrl #(
   parameter int COUNT_BITS = brsg_pkg::DEF_COUNT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             req_type,
   input  logic [brsg_pkg::NUM_IN_AXES-1:0] req_dir,
   input  logic [COUNT_BITS-1:0]            dist_or,
   output brsg_pkg::lane_ctl_type           lane_ctl,
   output brsg_pkg::ctrl_status_type        status
);
   import brsg_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   pending_full_ff, pending_full_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic [DEPTH_W-1:0]     pending_depth_ff, pending_depth_in;
   logic [COUNT_BITS-1:0]  index_ff, index_in;
   logic [NUM_IN_AXES-1:0] dir_ff, dir_in;
   logic [NUM_IN_AXES-1:0] pending_dir_ff, pending_dir_in;

   logic               is_load, is_tick, tick_act, last_slot;
   logic               load_active, load_pending, refused, promote;
   logic [DEPTH_W-1:0] new_depth, ones, bit_pos;

   // Depth of the incoming sub-movement: highest set bit plus one
   always_comb begin
      new_depth = DEPTH_W'(1);
      for (int b = 1; b < COUNT_BITS; b++) begin
         if (dist_or[b]) begin
            new_depth = DEPTH_W'(b + 1);
         end
      end
   end

   // Trailing ones of the count-down index
   always_comb begin
      ones = DEPTH_W'(COUNT_BITS);
      for (int b = COUNT_BITS - 1; b >= 0; b--) begin
         if (!index_ff[b]) begin
            ones = DEPTH_W'(b);
         end
      end
   end

   assign bit_pos = depth_ff - DEPTH_W'(1) - ones;

   // Transaction decode
   always_comb begin
      is_load      = push && (req_type == REQ_LOAD);
      is_tick      = push && (req_type == REQ_TICK);
      load_active  = is_load && !busy_ff;
      load_pending = is_load && busy_ff && !pending_full_ff;
      refused      = is_load && busy_ff && pending_full_ff;
      tick_act     = is_tick && busy_ff;
      last_slot    = (index_ff == '0);
      promote      = tick_act && last_slot && pending_full_ff;
   end

   // Next state
   always_comb begin
      busy_in          = busy_ff;
      pending_full_in  = pending_full_ff;
      depth_in         = depth_ff;
      pending_depth_in = pending_depth_ff;
      index_in         = index_ff;
      dir_in           = dir_ff;
      pending_dir_in   = pending_dir_ff;
      if (load_active) begin
         busy_in  = 1'b1;
         depth_in = new_depth;
         index_in = COUNT_BITS'(start_index(new_depth));
         dir_in   = req_dir;
      end
      if (load_pending) begin
         pending_full_in  = 1'b1;
         pending_depth_in = new_depth;
         pending_dir_in   = req_dir;
      end
      if (tick_act) begin
         if (!last_slot) begin
            index_in = index_ff - COUNT_BITS'(1);
         end else if (pending_full_ff) begin
            pending_full_in = 1'b0;
            depth_in        = pending_depth_ff;
            index_in        = COUNT_BITS'(start_index(pending_depth_ff));
            dir_in          = pending_dir_ff;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         pending_full_ff <= 1'b0;
         depth_ff        <= '0;
         index_ff        <= '0;
         dir_ff          <= '0;
      end else begin
         busy_ff         <= busy_in;
         pending_full_ff <= pending_full_in;
         depth_ff        <= depth_in;
         index_ff        <= index_in;
         dir_ff          <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_depth_ff <= pending_depth_in;
      pending_dir_ff   <= pending_dir_in;
   end

   // Lane control and status
   always_comb begin
      lane_ctl.load_active  = load_active;
      lane_ctl.load_pending = load_pending;
      lane_ctl.promote      = promote;
      lane_ctl.step_en      = tick_act && (ones < depth_ff);
      lane_ctl.bit_sel      = bit_pos[SEL_W-1:0];
      status.dir_out        = dir_in;
      status.step_valid     = tick_act;
      status.sub_done       = tick_act && last_slot;
      status.load_refused   = refused;
   end

endmodule

### rtl/binary_rate_step_generator.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid / req_ready | req_type, req_dist_axis0..3, req_dir_in
// rsp     | out | rsp_valid / rsp_ready | rsp_step_mask, rsp_dir_out, rsp_step_valid,
//         |     |                       | rsp_sub_done, rsp_load_refused
//
// One transaction per cycle while req_ready is high; each request gives one registered response.
// The per-axis lanes and the sequencer settle a tick combinationally.
// A two-entry output buffer (output register plus skid) keeps req_ready high
// while one response waits; req_ready drops only when both entries are full.
// Synchronous active-high reset clears the sequencer and the output buffer.
`include "binary_rate_step_generator_defines.svh"

module binary_rate_step_generator #(
   parameter int NUM_AXES   = brsg_pkg::DEF_NUM_AXES,
   parameter int COUNT_BITS = brsg_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [brsg_pkg::AXIS_COUNT_W-1:0] req_dist_axis0,
   input  logic [brsg_pkg::AXIS_COUNT_W-1:0] req_dist_axis1,
   input  logic [brsg_pkg::AXIS_COUNT_W-1:0] req_dist_axis2,
   input  logic [brsg_pkg::AXIS_COUNT_W-1:0] req_dist_axis3,
   input  logic [brsg_pkg::NUM_IN_AXES-1:0]  req_dir_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [brsg_pkg::NUM_IN_AXES-1:0]  rsp_step_mask,
   output logic [brsg_pkg::NUM_IN_AXES-1:0]  rsp_dir_out,
   output logic                              rsp_step_valid,
   output logic                              rsp_sub_done,
   output logic                              rsp_load_refused
);
   import brsg_pkg::*;

   localparam int USED_AXES = (NUM_AXES < NUM_IN_AXES) ? NUM_AXES : NUM_IN_AXES;

   logic                    push, pop;
   logic [AXIS_COUNT_W-1:0] axis_count [NUM_IN_AXES];
   logic [COUNT_BITS-1:0]   lane_count [NUM_IN_AXES];
   logic [NUM_IN_AXES-1:0]  lane_step;
   logic [COUNT_BITS-1:0]   dist_or;
   lane_ctl_type            lane_ctl;
   ctrl_status_type         status;
   rsp_type                 rsp_new;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   assign axis_count[0] = req_dist_axis0;
   assign axis_count[1] = req_dist_axis1;
   assign axis_count[2] = req_dist_axis2;
   assign axis_count[3] = req_dist_axis3;

   // Axis lanes; axes beyond NUM_AXES never step
   for (genvar a = 0; a < NUM_IN_AXES; a++) begin : g_lane
      if (a < USED_AXES) begin : g_used
         brsg_lane #(
            .COUNT_BITS (COUNT_BITS)
         ) u_lane (
            .clock       (clock),
            .reset       (reset),
            .axis_count  (axis_count[a]),
            .ctl         (lane_ctl),
            .dist_masked (lane_count[a]),
            .step        (lane_step[a])
         );
      end else begin : g_unused
         assign lane_count[a] = '0;
         assign lane_step[a]  = 1'b0;
      end
   end

   // Merge: OR of incoming counts for the depth search
   always_comb begin
      dist_or = '0;
      for (int a = 0; a < NUM_IN_AXES; a++) begin
         dist_or = dist_or | lane_count[a];
      end
   end

   brsg_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_type (req_type),
      .req_dir  (req_dir_in),
      .dist_or  (dist_or),
      .lane_ctl (lane_ctl),
      .status   (status)
   );

   // Merge: response assembly
   always_comb begin
      rsp_new.step_mask    = lane_step;
      rsp_new.dir_out      = status.dir_out;
      rsp_new.step_valid   = status.step_valid;
      rsp_new.sub_done     = status.sub_done;
      rsp_new.load_refused = status.load_refused;
   end

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_step_mask    = out_ff.step_mask;
   assign rsp_dir_out      = out_ff.dir_out;
   assign rsp_step_valid   = out_ff.step_valid;
   assign rsp_sub_done     = out_ff.sub_done;
   assign rsp_load_refused = out_ff.load_refused;

   // Checks
   `BRSG_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid entry without output entry")
   `BRSG_ASSERT_IMP(a_done_is_tick, clock, reset, rsp_valid && rsp_sub_done, rsp_step_valid, "sub_done without applied tick")
   `BRSG_ASSERT_IMP(a_refused_no_step, clock, reset, rsp_valid && rsp_load_refused, !rsp_step_valid && (rsp_step_mask == '0), "refused load carries steps")
   `BRSG_ASSERT_NXT(a_push_fills_out, clock, reset, push, out_valid_ff, "accepted transaction left no response")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import brsg_pkg::*;

   localparam int AXES   = DEF_NUM_AXES;
   localparam int CBITS  = DEF_COUNT_BITS;
   localparam int PERIOD = 10;

   typedef logic [NUM_IN_AXES-1:0][AXIS_COUNT_W-1:0] axis_counts_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_type = REQ_TICK;
   logic [AXIS_COUNT_W-1:0]     req_dist_axis0 = '0;
   logic [AXIS_COUNT_W-1:0]     req_dist_axis1 = '0;
   logic [AXIS_COUNT_W-1:0]     req_dist_axis2 = '0;
   logic [AXIS_COUNT_W-1:0]     req_dist_axis3 = '0;
   logic [NUM_IN_AXES-1:0]      req_dir_in = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [NUM_IN_AXES-1:0]      rsp_step_mask;
   logic [NUM_IN_AXES-1:0]      rsp_dir_out;
   logic                        rsp_step_valid;
   logic                        rsp_sub_done;
   logic                        rsp_load_refused;

   // Idle rates in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;

   // Expected responses, oldest first
   rsp_type step_result_q[$];

   // Shadow of the step sequencer
   axis_counts_type        act_counts = '0;
   logic [DEPTH_W-1:0]     act_depth = '0;
   logic [7:0]             act_index = '0;
   logic [NUM_IN_AXES-1:0] act_dir = '0;
   logic                   act_busy = 1'b0;
   axis_counts_type        pend_counts = '0;
   logic [NUM_IN_AXES-1:0] pend_dir = '0;
   logic                   pend_full = 1'b0;

   binary_rate_step_generator #(
      .NUM_AXES   (AXES),
      .COUNT_BITS (CBITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_dist_axis0   (req_dist_axis0),
      .req_dist_axis1   (req_dist_axis1),
      .req_dist_axis2   (req_dist_axis2),
      .req_dist_axis3   (req_dist_axis3),
      .req_dir_in       (req_dir_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_step_mask    (rsp_step_mask),
      .rsp_dir_out      (rsp_dir_out),
      .rsp_step_valid   (rsp_step_valid),
      .rsp_sub_done     (rsp_sub_done),
      .rsp_load_refused (rsp_load_refused)
   );

   // Clock
   always begin
      #(PERIOD / 2) clock = 1'b1;
      #(PERIOD / 2) clock = 1'b0;
   end

   // Counts as the block sees them: unused axes zero, counts clipped
   function automatic axis_counts_type clip_counts(input axis_counts_type counts);
      axis_counts_type c;
      c = '0;
      for (int i = 0; i < NUM_IN_AXES; i++)
         if (i < AXES)
            c[i] = counts[i] & AXIS_COUNT_W'((1 << CBITS) - 1);
      return c;
   endfunction

   // Highest set bit over all counts plus one, at least one
   function automatic int depth_of(input axis_counts_type counts);
      logic [AXIS_COUNT_W-1:0] all_bits;
      int d;
      all_bits = '0;
      for (int i = 0; i < NUM_IN_AXES; i++)
         all_bits = all_bits | counts[i];
      d = 1;
      while (d < 8 && (all_bits >> d) != 0)
         d++;
      return d;
   endfunction

   function automatic void activate_movement(input axis_counts_type counts,
                                             input logic [NUM_IN_AXES-1:0] dir);
      act_counts = clip_counts(counts);
      act_depth  = DEPTH_W'(depth_of(act_counts));
      act_index  = 8'((1 << act_depth) - 2);
      act_dir    = dir;
      act_busy   = 1'b1;
   endfunction

   // Apply one accepted transaction to the shadow state, return its response
   function automatic rsp_type predict_step_result(input req_kind_type kind,
                                                   input axis_counts_type counts,
                                                   input logic [NUM_IN_AXES-1:0] dir);
      rsp_type res;
      int ones;
      int bit_pos;
      res = '0;
      if (kind == REQ_LOAD) begin
         if (!act_busy) begin
            activate_movement(counts, dir);
         end else if (pend_full) begin
            res.load_refused = 1'b1;
         end else begin
            pend_counts = counts;
            pend_dir    = dir;
            pend_full   = 1'b1;
         end
      end else if (act_busy) begin
         ones = 0;
         while (ones < 8 && act_index[ones])
            ones++;
         if (ones < act_depth) begin
            bit_pos = act_depth - 1 - ones;
            for (int i = 0; i < AXES && i < NUM_IN_AXES; i++)
               if (act_counts[i][bit_pos])
                  res.step_mask[i] = 1'b1;
         end
         res.step_valid = 1'b1;
         if (act_index == 0) begin
            res.sub_done = 1'b1;
            if (pend_full) begin
               pend_full = 1'b0;
               activate_movement(pend_counts, pend_dir);
            end else begin
               act_busy = 1'b0;
            end
         end else begin
            act_index = act_index - 8'd1;
         end
      end
      res.dir_out = act_dir;
      return res;
   endfunction

   // Ticks until both the active and the pending sub-movement are done
   function automatic int ticks_left();
      int n;
      n = 0;
      if (act_busy) begin
         n = act_index + 1;
         if (pend_full)
            n += (1 << depth_of(clip_counts(pend_counts))) - 1;
      end
      return n;
   endfunction

   // Mostly short sub-movements, a few deep ones
   function automatic axis_counts_type random_counts();
      axis_counts_type c;
      int r;
      int width;
      r = $urandom_range(99);
      if (r < 3)
         width = 8;
      else if (r < 12)
         width = $urandom_range(7, 5);
      else
         width = $urandom_range(4, 1);
      for (int i = 0; i < NUM_IN_AXES; i++)
         c[i] = ($urandom_range(99) < 15) ? '0 : AXIS_COUNT_W'($urandom & ((1 << width) - 1));
      return c;
   endfunction

   // Send one transaction; called and returns at a falling edge
   task automatic send_item(input req_kind_type kind, input axis_counts_type counts,
                            input logic [NUM_IN_AXES-1:0] dir);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_dist_axis0 <= counts[0];
      req_dist_axis1 <= counts[1];
      req_dist_axis2 <= counts[2];
      req_dist_axis3 <= counts[3];
      req_dir_in     <= dir;
      do
         @(posedge clock);
      while (!req_ready);
      step_result_q.push_back(predict_step_result(kind, counts, dir));
      @(negedge clock);
   endtask

   task automatic send_load(input axis_counts_type counts, input logic [NUM_IN_AXES-1:0] dir);
      send_item(REQ_LOAD, counts, dir);
   endtask

   // Tick with junk in the unused payload
   task automatic send_tick();
      send_item(REQ_TICK, axis_counts_type'({$urandom, $urandom}), 4'($urandom));
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (step_result_q.size() != 0)
         @(negedge clock);
   endtask

   // Idle ticks, zero counts, pending fill, refused load, promotion
   task automatic test_directed();
      send_tick();
      send_load('0, 4'b0000);
      send_load({8'd0, 8'd2, 8'd1, 8'd3}, 4'b0101);
      send_load({8'd255, 8'd255, 8'd255, 8'd255}, 4'b1111);
      send_tick();
      repeat (3) send_tick();
      send_tick();
      send_load({8'd0, 8'd0, 8'd0, 8'd1}, 4'b1010);
      send_load({8'd2, 8'd0, 8'd1, 8'd0}, 4'b0110);
      repeat (5) send_tick();
      send_load({8'd5, 8'd6, 8'd7, 8'd4}, 4'b1001);
      repeat (8) send_tick();
   endtask

   // Full counts on every axis: deepest index range
   task automatic test_longest_movement();
      send_load({8'd255, 8'd255, 8'd255, 8'd255}, 4'b1111);
      send_load({8'd128, 8'd1, 8'd0, 8'd255}, 4'b0011);
      repeat (ticks_left() + 1) send_tick();
   endtask

   // Load bursts followed by ticks, with noise and cut-short sequences
   task automatic run_random_traffic(input int n_items);
      int sent;
      int ticks;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 8) begin
            if ($urandom_range(1))
               send_load(random_counts(), 4'($urandom));
            else
               send_tick();
            sent++;
         end else begin
            send_load(random_counts(), 4'($urandom));
            sent++;
            if ($urandom_range(1)) begin
               send_load(random_counts(), 4'($urandom));
               sent++;
            end
            if ($urandom_range(9) == 0) begin
               send_load(random_counts(), 4'($urandom));
               sent++;
            end
            ticks = ticks_left();
            if ($urandom_range(99) < 20)
               ticks = $urandom_range(ticks);
            else
               ticks += $urandom_range(2);
            repeat (ticks) send_tick();
            sent += ticks;
         end
      end
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      run_random_traffic(n_items / 2);
      // sender holds off until the response path is empty
      wait_results_drained();
      run_random_traffic(n_items - n_items / 2);
   endtask

   // Response side back-pressure
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (step_result_q.size() == 0) begin
            $display("%0t: unexpected response mask=%h dir=%h sv=%b done=%b ref=%b", $time,
                     rsp_step_mask, rsp_dir_out, rsp_step_valid, rsp_sub_done,
                     rsp_load_refused);
            mismatch_count++;
         end else begin
            want = step_result_q.pop_front();
            if (rsp_step_mask !== want.step_mask) begin
               $display("%0t: step_mask expected %h actual %h", $time, want.step_mask,
                        rsp_step_mask);
               mismatch_count++;
            end
            if (rsp_dir_out !== want.dir_out) begin
               $display("%0t: dir_out expected %h actual %h", $time, want.dir_out,
                        rsp_dir_out);
               mismatch_count++;
            end
            if (rsp_step_valid !== want.step_valid) begin
               $display("%0t: step_valid expected %b actual %b", $time, want.step_valid,
                        rsp_step_valid);
               mismatch_count++;
            end
            if (rsp_sub_done !== want.sub_done) begin
               $display("%0t: sub_done expected %b actual %b", $time, want.sub_done,
                        rsp_sub_done);
               mismatch_count++;
            end
            if (rsp_load_refused !== want.load_refused) begin
               $display("%0t: load_refused expected %b actual %b", $time, want.load_refused,
                        rsp_load_refused);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 32;
      recv_idle_pct = 66;
      test_directed();
      wait_results_drained();
      test_longest_movement();
      wait_results_drained();
      test_random_phase(32, 66, 220);
      test_random_phase(66, 32, 220);
      test_random_phase(0, 0, 220);
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/brsg_pkg.sv
rtl/brsg_lane.sv
rtl/brsg_ctrl.sv
rtl/binary_rate_step_generator.sv
test/tb_top.sv
